[rtl/charlieplex_188_led_scanner_macros.svh]
// Assertion macros used by the checker file of the LED scanner.
`ifndef CHARLIEPLEX_188_LED_SCANNER_MACROS_SVH
`define CHARLIEPLEX_188_LED_SCANNER_MACROS_SVH

// Concurrent assertion on a given clock and synchronous reset.
`define CLS188_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define CLS188_ASSERT_CLK(name, prop, msg) \
   `CLS188_ASSERT(name, clock, reset, prop, msg)

`endif

[rtl/cls188_pkg.sv]
// Package: action codes, segment font and phase decode for the LED scanner.
`default_nettype none

package cls188_pkg;

   // Action codes carried in the request beat
   localparam logic [1:0] ACT_SET_NUMBER  = 2'd0;
   localparam logic [1:0] ACT_SET_CHARGE  = 2'd1;
   localparam logic [1:0] ACT_SET_PERCENT = 2'd2;
   localparam logic [1:0] ACT_SCAN_TICK   = 2'd3;

   // Segment map layout
   localparam int MAP_W          = 18;
   localparam int TENS_LSB       = 7;
   localparam int HUND_B_BIT     = 14;
   localparam int HUND_C_BIT     = 15;
   localparam int CHARGE_BIT     = 16;
   localparam int PERCENT_BIT    = 17;
   localparam logic [7:0] FULL_SCALE = 8'd100;

   // Phase counter range
   localparam logic [2:0] PHASE_LAST = 3'd4;

   typedef logic [MAP_W-1:0] seg_map_type;

   // Seven-segment font, segments a..g in bits 0..6
   function automatic logic [6:0] digit_font(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

   // Pins driven in one phase: the phase pin plus the cathodes of its lit segments
   function automatic logic [4:0] phase_enable(input logic [2:0] phase,
                                               input seg_map_type map);
      logic [4:0] en;
      case (phase)
         3'd0:    en = {1'b0, map[4], map[2], map[0], 1'b1};
         3'd1:    en = {map[17], map[15], map[7], 1'b1, map[1]};
         3'd2:    en = {map[16], map[14], 1'b1, map[8], map[3]};
         3'd3:    en = {1'b0, 1'b1, map[9], map[10], map[5]};
         3'd4:    en = {1'b1, map[13], map[12], map[11], map[6]};
         default: en = 5'b0;
      endcase
      return en;
   endfunction

endpackage

`default_nettype wire

[rtl/cls188_if.sv]
// Interfaces: request and response channels of the LED scanner.
`default_nettype none

interface cls188_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] value;
   logic       flag;

   modport source (output valid, output action, output value, output flag, input ready);
   modport sink   (input valid, input action, input value, input flag, output ready);
endinterface

interface cls188_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] pin_enable;
   logic [4:0] pin_level;
   logic [2:0] scan_phase;

   modport source (output valid, output pin_enable, output pin_level, output scan_phase,
                   input ready);
   modport sink   (input valid, input pin_enable, input pin_level, input scan_phase,
                   output ready);
endinterface

`default_nettype wire

[rtl/charlieplex_188_led_scanner.sv]
// Top level: five-pin charlieplexed 188 display scanner.
//
// Request beats either update the segment map (number 0..100, charge icon,
// percent icon) or ask for a scan tick. Each beat is registered in the input
// register and decoded and, for a scan tick, the pin masks of the current
// phase are placed in the response register. One beat is taken every cycle
// while the response side does not stall a scan tick. Write beats give no
// response and never wait on the response side. A held response stalls the
// scan tick sitting in the input register, and with it every beat queued
// behind that tick, until the response is taken.
`default_nettype none

module charlieplex_188_led_scanner
   import cls188_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   cls188_req_if.sink   req_ch,
   cls188_rsp_if.source rsp_ch
);

   // Input register
   logic       req_valid_ff, req_valid_in;
   logic [1:0] req_action_ff;
   logic [7:0] req_value_ff;
   logic       req_flag_ff;

   // Display state
   seg_map_type map_ff, map_in;
   logic [2:0]  phase_ff, phase_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_enable_ff;
   logic [4:0] rsp_level_ff;
   logic [2:0] rsp_phase_ff;

   logic        rsp_free;
   logic        is_scan;
   logic        advance;
   logic [15:0] tens_prod;
   logic [3:0]  tens;
   logic [7:0]  ones_wide;
   logic [3:0]  ones;
   seg_map_type number_map;

   // Handshake: a write beat always drains, a scan tick waits for a free response slot
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_scan      = (req_action_ff == ACT_SCAN_TICK);
   assign advance      = req_valid_ff && (!is_scan || rsp_free);
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_valid_in = req_ch.valid ? 1'b1 : (advance ? 1'b0 : req_valid_ff);

   // Split the number into digits: divide by ten through reciprocal 205/2048
   assign tens_prod = {8'd0, req_value_ff} * 16'd205;
   assign tens      = tens_prod[14:11];
   assign ones_wide = req_value_ff - {1'b0, tens, 3'b000} - {3'b000, tens, 1'b0};
   assign ones      = ones_wide[3:0];

   // Build the digit part of the map; icons come from the current map
   always_comb begin
      number_map              = map_ff;
      number_map[HUND_C_BIT]  = 1'b0;
      number_map[HUND_B_BIT]  = 1'b0;
      number_map[TENS_LSB+:7] = 7'h00;
      number_map[6:0]         = 7'h00;
      if (req_value_ff == FULL_SCALE) begin
         number_map[HUND_C_BIT]  = 1'b1;
         number_map[HUND_B_BIT]  = 1'b1;
         number_map[TENS_LSB+:7] = digit_font(4'd0);
         number_map[6:0]         = digit_font(4'd0);
      end else begin
         if (tens != 4'd0) begin
            number_map[TENS_LSB+:7] = digit_font(tens);
         end
         number_map[6:0] = digit_font(ones);
      end
   end

   // Next state of the map and the phase counter
   always_comb begin
      map_in   = map_ff;
      phase_in = phase_ff;
      if (advance) begin
         case (req_action_ff)
            ACT_SET_NUMBER: begin
               if (req_value_ff <= FULL_SCALE) begin
                  map_in = number_map;
               end
            end
            ACT_SET_CHARGE:  map_in[CHARGE_BIT]  = req_flag_ff;
            ACT_SET_PERCENT: map_in[PERCENT_BIT] = req_flag_ff;
            ACT_SCAN_TICK: begin
               phase_in = (phase_ff >= PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
            end
            default: map_in = map_ff;
         endcase
      end
   end

   // Response slot: load on a scan tick, drop once taken
   assign rsp_valid_in = (advance && is_scan) ? 1'b1 :
                         (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_ff       <= '0;
         phase_ff     <= 3'd0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
         phase_ff     <= phase_in;
      end
   end

   // Payload registers: capture the request beat, hold the response beat
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_action_ff <= req_ch.action;
         req_value_ff  <= req_ch.value;
         req_flag_ff   <= req_ch.flag;
      end
      if (advance && is_scan) begin
         rsp_enable_ff <= phase_enable(phase_ff, map_ff);
         rsp_level_ff  <= 5'd1 << phase_ff;
         rsp_phase_ff  <= phase_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pin_enable = rsp_enable_ff;
   assign rsp_ch.pin_level  = rsp_level_ff;
   assign rsp_ch.scan_phase = rsp_phase_ff;

endmodule

`default_nettype wire

[rtl/cls188_checker.sv]
// Checker: port-level assertions on the LED scanner, bound to the top level.
`default_nettype none

`include "charlieplex_188_led_scanner_macros.svh"

module cls188_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [4:0] pin_enable,
   input wire logic [4:0] pin_level,
   input wire logic [2:0] scan_phase
);

   // Hold a stalled response beat
   `CLS188_ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(pin_enable) && $stable(pin_level) && $stable(scan_phase), "stalled response beat changed")

   // Phase in range and only its own pin driven high
   `CLS188_ASSERT_CLK(a_phase_level, rsp_valid |-> scan_phase <= 3'd4 && pin_level == (5'd1 << scan_phase), "pin level does not match scan phase")

   // The high pin is always enabled
   `CLS188_ASSERT_CLK(a_level_enabled, rsp_valid |-> (pin_enable & pin_level) == pin_level, "phase pin not enabled")

   // Successive scan beats step the phase by one, wrapping after four
   `CLS188_ASSERT_CLK(a_phase_step, rsp_valid && rsp_ready ##1 rsp_valid |-> scan_phase == (($past(scan_phase) == 3'd4) ? 3'd0 : $past(scan_phase) + 3'd1) || $stable(scan_phase), "scan phase skipped")

endmodule

bind charlieplex_188_led_scanner cls188_checker u_cls188_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .pin_enable (rsp_ch.pin_enable),
   .pin_level  (rsp_ch.pin_level),
   .scan_phase (rsp_ch.scan_phase)
);

`default_nettype wire
